/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the character LCD controller.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge outside reset.
`define ASSERT_CLK(label, clock, resetn, prop, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (prop)) \
        else $error(msg);

// Check that an antecedent implies a consequent on the same edge.
`define ASSERT_IMPLY(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that an antecedent implies a consequent on the next edge.
`define ASSERT_NEXT(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/clcd_pkg.sv */
// ----------------------------------------------------------------------------
// clcd_pkg
// Types, constants and helpers for the 4-bit character LCD controller.
// ----------------------------------------------------------------------------
package clcd_pkg;

    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned NIB_W     = 4;
    localparam int unsigned PHASE_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_POWER_ON_WAIT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_INIT_WAIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_INIT_WAIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_SETTLE_WAIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_WAIT        = 3'd4;

    localparam logic [CFG_W-1:0] POWER_ON_WAIT_RST     = 16'd15000;
    localparam logic [CFG_W-1:0] LONG_INIT_WAIT_RST    = 16'd5000;
    localparam logic [CFG_W-1:0] SHORT_INIT_WAIT_RST   = 16'd100;
    localparam logic [CFG_W-1:0] WRITE_SETTLE_WAIT_RST = 16'd40;
    localparam logic [CFG_W-1:0] CLEAR_WAIT_RST        = 16'd2000;

    localparam logic [BYTE_W-1:0] CMD_FUNCTION_SET = 8'h28;
    localparam logic [BYTE_W-1:0] CMD_DISPLAY_OFF  = 8'h08;
    localparam logic [BYTE_W-1:0] CMD_DISPLAY_ON   = 8'h0C;
    localparam logic [BYTE_W-1:0] CMD_ENTRY_MODE   = 8'h06;
    localparam logic [BYTE_W-1:0] CMD_CLEAR        = 8'h01;
    localparam logic [BYTE_W-1:0] CMD_NONE         = 8'h00;

    localparam logic [NIB_W-1:0] NIB_ATTENTION = 4'h3;
    localparam logic [NIB_W-1:0] NIB_FOUR_BIT  = 4'h2;

    localparam logic [PHASE_W-1:0] PH_HIGH = 2'd0;
    localparam logic [PHASE_W-1:0] PH_GAP  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_LOW  = 2'd2;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    typedef enum logic [14:0] {
        ST_PWR     = 15'h0001,
        ST_ATT1    = 15'h0002,
        ST_W1      = 15'h0004,
        ST_ATT2    = 15'h0008,
        ST_W2      = 15'h0010,
        ST_ATT3    = 15'h0020,
        ST_W3      = 15'h0040,
        ST_MODE    = 15'h0080,
        ST_W4      = 15'h0100,
        ST_IXFER   = 15'h0200,
        ST_ISETTLE = 15'h0400,
        ST_HXFER   = 15'h0800,
        ST_HSETTLE = 15'h1000,
        ST_HCLEAR  = 15'h2000,
        ST_IDLE    = 15'h4000
    } step_t;

    typedef struct packed {
        logic [CFG_W-1:0] power_on_wait;
        logic [CFG_W-1:0] long_init_wait;
        logic [CFG_W-1:0] short_init_wait;
        logic [CFG_W-1:0] write_settle_wait;
        logic [CFG_W-1:0] clear_wait;
    } cfg_t;

    typedef struct packed {
        logic                 en;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_W-1:0]     data;
    } cfg_wr_t;

    typedef struct packed {
        logic              kind;
        logic              reg_select;
        logic [BYTE_W-1:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [NIB_W-1:0] bus_nibble;
        logic             rs_line;
        logic             enable_line;
        logic             busy_res;
        logic             rejected;
    } result_t;

    function automatic logic [BYTE_W-1:0] next_init_byte(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] nb;
        case (b)
            CMD_FUNCTION_SET: nb = CMD_DISPLAY_OFF;
            CMD_DISPLAY_OFF:  nb = CMD_DISPLAY_ON;
            CMD_DISPLAY_ON:   nb = CMD_ENTRY_MODE;
            default:          nb = CMD_NONE;
        endcase
        return nb;
    endfunction

endpackage

/* hw/rtl/clcd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// clcd_cfg_regs
// Wait-time configuration registers with their power-on defaults.
// ----------------------------------------------------------------------------
module clcd_cfg_regs
(
    input  logic              clk,
    input  logic              rst_n,
    input  clcd_pkg::cfg_wr_t cfg_wr,
    output clcd_pkg::cfg_t    cfg
);

    clcd_pkg::cfg_t cfg_reg;
    clcd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr.en)
        begin
            case (cfg_wr.index)
                clcd_pkg::CFG_POWER_ON_WAIT:     cfg_next.power_on_wait     = cfg_wr.data;
                clcd_pkg::CFG_LONG_INIT_WAIT:    cfg_next.long_init_wait    = cfg_wr.data;
                clcd_pkg::CFG_SHORT_INIT_WAIT:   cfg_next.short_init_wait   = cfg_wr.data;
                clcd_pkg::CFG_WRITE_SETTLE_WAIT: cfg_next.write_settle_wait = cfg_wr.data;
                clcd_pkg::CFG_CLEAR_WAIT:        cfg_next.clear_wait        = cfg_wr.data;
                default:                         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.power_on_wait     <= clcd_pkg::POWER_ON_WAIT_RST;
            cfg_reg.long_init_wait    <= clcd_pkg::LONG_INIT_WAIT_RST;
            cfg_reg.short_init_wait   <= clcd_pkg::SHORT_INIT_WAIT_RST;
            cfg_reg.write_settle_wait <= clcd_pkg::WRITE_SETTLE_WAIT_RST;
            cfg_reg.clear_wait        <= clcd_pkg::CLEAR_WAIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hw/rtl/clcd_seq.sv */
// ----------------------------------------------------------------------------
// clcd_seq
// Init and transfer sequencer: advances at most one step per beat and forms the
// bus levels for that beat.
// ----------------------------------------------------------------------------
module clcd_seq
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  clcd_pkg::item_t   item,
    input  clcd_pkg::cfg_t    cfg,
    input  clcd_pkg::cfg_wr_t cfg_wr,
    output clcd_pkg::result_t result
);

    clcd_pkg::step_t                      step_reg,      step_next;
    logic [clcd_pkg::CFG_W-1:0]           wait_cnt_reg,  wait_cnt_next;
    logic [clcd_pkg::BYTE_W-1:0]          held_byte_reg, held_byte_next;
    logic                                 held_rs_reg,   held_rs_next;
    logic [clcd_pkg::PHASE_W-1:0]         phase_reg,     phase_next;
    logic [clcd_pkg::NIB_W-1:0]           bus_reg,       bus_next;
    logic                                 rs_reg,        rs_next;

    logic                                 wait_done;
    logic [clcd_pkg::CFG_W-1:0]           wait_dec;
    logic                                 xfer_done;
    logic                                 en;
    logic                                 rej;
    logic [clcd_pkg::BYTE_W-1:0]          init_nb;

    assign wait_done = (wait_cnt_reg <= 16'd1);
    assign wait_dec  = wait_done ? '0 : wait_cnt_reg - 16'd1;
    assign init_nb   = clcd_pkg::next_init_byte(held_byte_reg);

    always_comb
    begin
        step_next      = step_reg;
        wait_cnt_next  = wait_cnt_reg;
        held_byte_next = held_byte_reg;
        held_rs_next   = held_rs_reg;
        phase_next     = phase_reg;
        bus_next       = bus_reg;
        rs_next        = rs_reg;
        en             = 1'b0;
        rej            = 1'b0;
        xfer_done      = 1'b0;

        if (fire && item.kind == clcd_pkg::KIND_WRITE)
        begin
            if (step_reg == clcd_pkg::ST_IDLE)
            begin
                held_rs_next   = item.reg_select;
                held_byte_next = item.data_byte;
                rs_next        = item.reg_select;
                phase_next     = clcd_pkg::PH_HIGH;
                step_next      = clcd_pkg::ST_HXFER;
            end
            else
            begin
                rej = 1'b1;
            end
        end
        else if (fire)
        begin
            // nibble transfer, shared by init bytes and host bytes
            if (step_reg == clcd_pkg::ST_IXFER || step_reg == clcd_pkg::ST_HXFER)
            begin
                case (phase_reg)
                    clcd_pkg::PH_HIGH:
                    begin
                        bus_next   = held_byte_reg[7:4];
                        en         = 1'b1;
                        phase_next = clcd_pkg::PH_GAP;
                    end
                    clcd_pkg::PH_GAP:
                    begin
                        phase_next = clcd_pkg::PH_LOW;
                    end
                    default:
                    begin
                        bus_next      = held_byte_reg[3:0];
                        en            = 1'b1;
                        phase_next    = clcd_pkg::PH_HIGH;
                        wait_cnt_next = cfg.write_settle_wait;
                        xfer_done     = 1'b1;
                    end
                endcase
            end

            case (step_reg)
                clcd_pkg::ST_PWR:
                begin
                    wait_cnt_next = wait_dec;
                    if (wait_done)
                        step_next = clcd_pkg::ST_ATT1;
                end
                clcd_pkg::ST_ATT1:
                begin
                    bus_next      = clcd_pkg::NIB_ATTENTION;
                    rs_next       = 1'b0;
                    en            = 1'b1;
                    wait_cnt_next = cfg.long_init_wait;
                    step_next     = clcd_pkg::ST_W1;
                end
                clcd_pkg::ST_W1:
                begin
                    wait_cnt_next = wait_dec;
                    if (wait_done)
                        step_next = clcd_pkg::ST_ATT2;
                end
                clcd_pkg::ST_ATT2:
                begin
                    bus_next      = clcd_pkg::NIB_ATTENTION;
                    rs_next       = 1'b0;
                    en            = 1'b1;
                    wait_cnt_next = cfg.short_init_wait;
                    step_next     = clcd_pkg::ST_W2;
                end
                clcd_pkg::ST_W2:
                begin
                    wait_cnt_next = wait_dec;
                    if (wait_done)
                        step_next = clcd_pkg::ST_ATT3;
                end
                clcd_pkg::ST_ATT3:
                begin
                    bus_next      = clcd_pkg::NIB_ATTENTION;
                    rs_next       = 1'b0;
                    en            = 1'b1;
                    wait_cnt_next = cfg.long_init_wait;
                    step_next     = clcd_pkg::ST_W3;
                end
                clcd_pkg::ST_W3:
                begin
                    wait_cnt_next = wait_dec;
                    if (wait_done)
                        step_next = clcd_pkg::ST_MODE;
                end
                clcd_pkg::ST_MODE:
                begin
                    bus_next      = clcd_pkg::NIB_FOUR_BIT;
                    rs_next       = 1'b0;
                    en            = 1'b1;
                    wait_cnt_next = cfg.write_settle_wait;
                    step_next     = clcd_pkg::ST_W4;
                end
                clcd_pkg::ST_W4:
                begin
                    wait_cnt_next = wait_dec;
                    if (wait_done)
                    begin
                        held_byte_next = clcd_pkg::CMD_FUNCTION_SET;
                        held_rs_next   = 1'b0;
                        phase_next     = clcd_pkg::PH_HIGH;
                        step_next      = clcd_pkg::ST_IXFER;
                    end
                end
                clcd_pkg::ST_IXFER:
                begin
                    if (xfer_done)
                        step_next = clcd_pkg::ST_ISETTLE;
                end
                clcd_pkg::ST_ISETTLE:
                begin
                    wait_cnt_next = wait_dec;
                    if (wait_done)
                    begin
                        if (init_nb == clcd_pkg::CMD_NONE)
                        begin
                            step_next = clcd_pkg::ST_IDLE;
                        end
                        else
                        begin
                            held_byte_next = init_nb;
                            phase_next     = clcd_pkg::PH_HIGH;
                            step_next      = clcd_pkg::ST_IXFER;
                        end
                    end
                end
                clcd_pkg::ST_HXFER:
                begin
                    if (xfer_done)
                        step_next = clcd_pkg::ST_HSETTLE;
                end
                clcd_pkg::ST_HSETTLE:
                begin
                    wait_cnt_next = wait_dec;
                    if (wait_done)
                    begin
                        if (!held_rs_reg && held_byte_reg == clcd_pkg::CMD_CLEAR)
                        begin
                            wait_cnt_next = cfg.clear_wait;
                            step_next     = clcd_pkg::ST_HCLEAR;
                        end
                        else
                        begin
                            step_next = clcd_pkg::ST_IDLE;
                        end
                    end
                end
                clcd_pkg::ST_HCLEAR:
                begin
                    wait_cnt_next = wait_dec;
                    if (wait_done)
                        step_next = clcd_pkg::ST_IDLE;
                end
                default:
                begin
                    step_next = clcd_pkg::ST_IDLE;
                end
            endcase
        end

        // restart the power-on wait when its length is rewritten while it runs
        if (cfg_wr.en && cfg_wr.index == clcd_pkg::CFG_POWER_ON_WAIT
            && step_reg == clcd_pkg::ST_PWR)
            wait_cnt_next = cfg_wr.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= clcd_pkg::ST_PWR;
            wait_cnt_reg  <= clcd_pkg::POWER_ON_WAIT_RST;
            held_byte_reg <= '0;
            held_rs_reg   <= 1'b0;
            phase_reg     <= clcd_pkg::PH_HIGH;
            bus_reg       <= '0;
            rs_reg        <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            wait_cnt_reg  <= wait_cnt_next;
            held_byte_reg <= held_byte_next;
            held_rs_reg   <= held_rs_next;
            phase_reg     <= phase_next;
            bus_reg       <= bus_next;
            rs_reg        <= rs_next;
        end
    end

    always_comb
    begin
        result.bus_nibble  = bus_next;
        result.rs_line     = rs_next;
        result.enable_line = en;
        result.busy_res    = (step_next != clcd_pkg::ST_IDLE);
        result.rejected    = rej;
    end

endmodule

/* hw/rtl/char_lcd_four_bit_interface_core.sv */
// ----------------------------------------------------------------------------
// char_lcd_four_bit_interface_core
// Character LCD controller for a 4-bit bus: power-on init, byte transfers
// as two strobed nibbles, settle and clear waits counted in tick beats.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------
//   in       | in_valid / in_ready    | kind, reg_select, data_byte
//   out      | out_valid / out_ready  | bus_nibble, rs_line, enable_line,
//            |                        | busy_res, rejected
//   cfg      | cfg_wr_en              | cfg_index, cfg_data
//
// One beat in, one beat out; a beat may enter every cycle while the output is not stalled.
// The path runs through the input register, sequencer step and result register.
// The result register holds while out_valid is high and out_ready is low; the input
// register still takes a beat, so the stall reaches in_ready once that register is full.
// Reset puts the sequencer at the start of the power-on wait, defaults in
// the wait registers and the sequencer's bus and rs registers low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module char_lcd_four_bit_interface_core
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              kind,
    input  logic                              reg_select,
    input  logic [clcd_pkg::BYTE_W-1:0]       data_byte,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [clcd_pkg::NIB_W-1:0]        bus_nibble,
    output logic                              rs_line,
    output logic                              enable_line,
    output logic                              busy_res,
    output logic                              rejected,

    input  logic                              cfg_wr_en,
    input  logic [clcd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [clcd_pkg::CFG_W-1:0]        cfg_data
);

    logic              in_valid_reg,  in_valid_next;
    clcd_pkg::item_t   item_reg;
    logic              out_valid_reg, out_valid_next;
    clcd_pkg::result_t result_reg;
    clcd_pkg::result_t result_comb;
    clcd_pkg::cfg_t    cfg;
    clcd_pkg::cfg_wr_t cfg_wr;
    logic              advance;
    logic              accept;

    assign cfg_wr.en    = cfg_wr_en;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.kind       <= kind;
            item_reg.reg_select <= reg_select;
            item_reg.data_byte  <= data_byte;
        end
        if (advance)
            result_reg <= result_comb;
    end

    clcd_cfg_regs u_cfg
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_wr (cfg_wr),
        .cfg    (cfg)
    );

    clcd_seq u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (item_reg),
        .cfg    (cfg),
        .cfg_wr (cfg_wr),
        .result (result_comb)
    );

    assign out_valid   = out_valid_reg;
    assign bus_nibble  = result_reg.bus_nibble;
    assign rs_line     = result_reg.rs_line;
    assign enable_line = result_reg.enable_line;
    assign busy_res    = result_reg.busy_res;
    assign rejected    = result_reg.rejected;

    `ASSERT_IMPLY(a_strobe_busy, clk, rst_n, out_valid && enable_line, busy_res, "strobe while idle")
    `ASSERT_IMPLY(a_reject_quiet, clk, rst_n, out_valid && rejected, busy_res && !enable_line, "reject not quiet")
    `ASSERT_NEXT(a_advance_out, clk, rst_n, advance, out_valid_reg, "result lost after step")

endmodule

/* test/lcd_bus_checker.sv */
// ----------------------------------------------------------------------------
// lcd_bus_checker
// Watches the beat and register ports of the 4-bit character LCD controller,
// keeps its own model of the init and transfer sequencer, and compares every
// output beat field by field against the oldest predicted bus state.
// ----------------------------------------------------------------------------
module lcd_bus_checker
    import clcd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 kind,
    input  logic                 reg_select,
    input  logic [BYTE_W-1:0]    data_byte,

    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [NIB_W-1:0]     bus_nibble,
    input  logic                 rs_line,
    input  logic                 enable_line,
    input  logic                 busy_res,
    input  logic                 rejected,

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,

    output int                   mismatches,
    output int                   pending,
    output int                   beats_out,
    output int                   rejects_seen,
    output int                   strobes_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [PHASE_W-1:0] PH_LOW = 2'd2;
    localparam int PRINT_CAP = 30;

    cfg_t              wait_regs;
    step_t             lcd_step;
    logic [CFG_W-1:0]  wait_left;
    logic [BYTE_W-1:0] held_byte;
    logic              held_rs;
    logic [PHASE_W-1:0] nib_phase;
    logic [NIB_W-1:0]  bus_level;
    logic              rs_level;
    result_t           bus_expected[$];

    function automatic logic wait_over();
        if (wait_left <= 1)
        begin
            wait_left = '0;
            return 1'b1;
        end
        wait_left = wait_left - 1'b1;
        return 1'b0;
    endfunction

    function automatic logic send_nibble(output logic strobe);
        logic finished;
        finished = 1'b0;
        strobe = 1'b1;
        case (nib_phase)
            PH_HIGH:
            begin
                bus_level = held_byte[7:4];
                nib_phase = PH_GAP;
            end
            PH_GAP:
            begin
                strobe = 1'b0;
                nib_phase = PH_LOW;
            end
            default:
            begin
                bus_level = held_byte[3:0];
                nib_phase = PH_HIGH;
                wait_left = wait_regs.write_settle_wait;
                finished = 1'b1;
            end
        endcase
        return finished;
    endfunction

    function automatic logic advance_tick();
        logic              strobe;
        logic [BYTE_W-1:0] next_byte;
        strobe = 1'b0;
        case (lcd_step)
            ST_PWR:
                if (wait_over()) lcd_step = ST_ATT1;
            ST_ATT1, ST_ATT2, ST_ATT3, ST_MODE:
            begin
                bus_level = (lcd_step == ST_MODE) ? NIB_FOUR_BIT : NIB_ATTENTION;
                rs_level = 1'b0;
                strobe = 1'b1;
                case (lcd_step)
                    ST_ATT1:
                    begin
                        wait_left = wait_regs.long_init_wait;
                        lcd_step = ST_W1;
                    end
                    ST_ATT2:
                    begin
                        wait_left = wait_regs.short_init_wait;
                        lcd_step = ST_W2;
                    end
                    ST_ATT3:
                    begin
                        wait_left = wait_regs.long_init_wait;
                        lcd_step = ST_W3;
                    end
                    default:
                    begin
                        wait_left = wait_regs.write_settle_wait;
                        lcd_step = ST_W4;
                    end
                endcase
            end
            ST_W1:
                if (wait_over()) lcd_step = ST_ATT2;
            ST_W2:
                if (wait_over()) lcd_step = ST_ATT3;
            ST_W3:
                if (wait_over()) lcd_step = ST_MODE;
            ST_W4:
                if (wait_over())
                begin
                    held_byte = CMD_FUNCTION_SET;
                    held_rs = 1'b0;
                    nib_phase = PH_HIGH;
                    lcd_step = ST_IXFER;
                end
            ST_IXFER:
                if (send_nibble(strobe)) lcd_step = ST_ISETTLE;
            ST_ISETTLE:
                if (wait_over())
                begin
                    case (held_byte)
                        CMD_FUNCTION_SET: next_byte = CMD_DISPLAY_OFF;
                        CMD_DISPLAY_OFF:  next_byte = CMD_DISPLAY_ON;
                        CMD_DISPLAY_ON:   next_byte = CMD_ENTRY_MODE;
                        default:          next_byte = CMD_NONE;
                    endcase
                    if (next_byte == CMD_NONE)
                        lcd_step = ST_IDLE;
                    else
                    begin
                        held_byte = next_byte;
                        nib_phase = PH_HIGH;
                        lcd_step = ST_IXFER;
                    end
                end
            ST_HXFER:
                if (send_nibble(strobe)) lcd_step = ST_HSETTLE;
            ST_HSETTLE:
                if (wait_over())
                begin
                    if (!held_rs && held_byte == CMD_CLEAR)
                    begin
                        wait_left = wait_regs.clear_wait;
                        lcd_step = ST_HCLEAR;
                    end
                    else
                        lcd_step = ST_IDLE;
                end
            ST_HCLEAR:
                if (wait_over()) lcd_step = ST_IDLE;
            default:
                lcd_step = ST_IDLE;
        endcase
        return strobe;
    endfunction

    function automatic result_t predict_bus(input logic k, input logic rs,
                                            input logic [BYTE_W-1:0] b);
        result_t r;
        logic    strobe;
        logic    dropped;
        strobe = 1'b0;
        dropped = 1'b0;
        if (k == KIND_WRITE)
        begin
            if (lcd_step == ST_IDLE)
            begin
                held_rs = rs;
                held_byte = b;
                rs_level = rs;
                nib_phase = PH_HIGH;
                lcd_step = ST_HXFER;
            end
            else
                dropped = 1'b1;
        end
        else
            strobe = advance_tick();
        r.bus_nibble = bus_level;
        r.rs_line = rs_level;
        r.enable_line = strobe;
        r.busy_res = (lcd_step != ST_IDLE);
        r.rejected = dropped;
        return r;
    endfunction

    task automatic store_wait_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        case (idx)
            CFG_POWER_ON_WAIT:
            begin
                wait_regs.power_on_wait = val;
                if (lcd_step == ST_PWR) wait_left = val;
            end
            CFG_LONG_INIT_WAIT:    wait_regs.long_init_wait = val;
            CFG_SHORT_INIT_WAIT:   wait_regs.short_init_wait = val;
            CFG_WRITE_SETTLE_WAIT: wait_regs.write_settle_wait = val;
            CFG_CLEAR_WAIT:        wait_regs.clear_wait = val;
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("%0t: beat %0d: %s", $time, beats_out, what);
    endtask

    task automatic check_bus(input result_t want);
        if (bus_nibble !== want.bus_nibble)
            report_mismatch($sformatf("bus_nibble %h, expected %h", bus_nibble, want.bus_nibble));
        if (rs_line !== want.rs_line)
            report_mismatch($sformatf("rs_line %b, expected %b", rs_line, want.rs_line));
        if (enable_line !== want.enable_line)
            report_mismatch($sformatf("enable_line %b, expected %b",
                                      enable_line, want.enable_line));
        if (busy_res !== want.busy_res)
            report_mismatch($sformatf("busy_res %b, expected %b", busy_res, want.busy_res));
        if (rejected !== want.rejected)
            report_mismatch($sformatf("rejected %b, expected %b", rejected, want.rejected));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_regs.power_on_wait = POWER_ON_WAIT_RST;
            wait_regs.long_init_wait = LONG_INIT_WAIT_RST;
            wait_regs.short_init_wait = SHORT_INIT_WAIT_RST;
            wait_regs.write_settle_wait = WRITE_SETTLE_WAIT_RST;
            wait_regs.clear_wait = CLEAR_WAIT_RST;
            lcd_step = ST_PWR;
            wait_left = POWER_ON_WAIT_RST;
            held_byte = '0;
            held_rs = 1'b0;
            nib_phase = PH_HIGH;
            bus_level = '0;
            rs_level = 1'b0;
            bus_expected.delete();
            mismatches = 0;
            pending = 0;
            beats_out = 0;
            rejects_seen = 0;
            strobes_seen = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                beats_out++;
                if (rejected === 1'b1) rejects_seen++;
                if (enable_line === 1'b1) strobes_seen++;
                if (bus_expected.size() == 0)
                    report_mismatch("output beat with nothing outstanding");
                else
                    check_bus(bus_expected.pop_front());
            end
            if (cfg_wr_en)
                store_wait_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
                bus_expected.push_back(predict_bus(kind, reg_select, data_byte));
            pending = bus_expected.size();
        end
    end

endmodule

/* test/char_lcd_four_bit_interface_core_tb.sv */
// ----------------------------------------------------------------------------
// char_lcd_four_bit_interface_core_tb
// Drives tick and write beats into the 4-bit LCD controller through the
// power-on sequence, directed byte writes and clears, then random write and
// tick streams under several idling mixes, a long output hold-off and
// extreme wait settings; the checker beside the block scores every beat.
// ----------------------------------------------------------------------------
module char_lcd_four_bit_interface_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import clcd_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int HOLD_CYCLES = 64;
    localparam int DRAIN_CYCLES = 6;
    localparam int RANDOM_BEATS = 200;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam logic [BYTE_W-1:0]    CMD_SET_CURSOR = 8'h80;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic                 kind;
    logic                 reg_select;
    logic [BYTE_W-1:0]    data_byte;
    logic                 out_valid;
    logic                 out_ready;
    logic [NIB_W-1:0]     bus_nibble;
    logic                 rs_line;
    logic                 enable_line;
    logic                 busy_res;
    logic                 rejected;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int mismatches;
    int pending;
    int beats_out;
    int rejects_seen;
    int strobes_seen;

    logic in_fire = 1'b0;
    bit   hold_req = 1'b0;
    bit   hold_done = 1'b0;
    int   send_idle = 0;
    int   recv_stall = 0;
    int   beats_in = 0;
    int   cfg_writes = 0;
    int   cycle_count = 0;
    int   settle_now = 1;
    int   clear_now = 1;

    char_lcd_four_bit_interface_core uut (.*);

    lcd_bus_checker u_checker (.*);

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
        in_fire <= in_valid && in_ready;

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                out_ready <= 1'b0;
                hold_done <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("char_lcd_four_bit_interface_core: mismatch");
        $finish;
    end

    task automatic send_beat(input logic k, input logic rs, input logic [BYTE_W-1:0] b);
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < send_idle) @(negedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        reg_select <= rs;
        data_byte <= b;
        @(negedge clk);
        while (!in_fire) @(negedge clk);
        beats_in++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_beat(KIND_TICK, 1'($urandom_range(1)), BYTE_W'($urandom_range(255)));
    endtask

    task automatic drain_pipe();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // hold the write enable high across a batch; end_writes drops it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_writes++;
    endtask

    task automatic end_writes();
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic program_waits(input int pwr, input int long_w, input int short_w,
                                 input int settle, input int clear);
        write_reg(CFG_POWER_ON_WAIT, CFG_W'(pwr));
        write_reg(CFG_LONG_INIT_WAIT, CFG_W'(long_w));
        write_reg(CFG_SHORT_INIT_WAIT, CFG_W'(short_w));
        write_reg(CFG_WRITE_SETTLE_WAIT, CFG_W'(settle));
        write_reg(CFG_CLEAR_WAIT, CFG_W'(clear));
        end_writes();
        settle_now = (settle == 0) ? 1 : settle;
        clear_now = (clear == 0) ? 1 : clear;
    endtask

    function automatic int xfer_ticks(input logic is_clear);
        return 3 + settle_now + (is_clear ? clear_now : 0);
    endfunction

    task automatic random_phase(input int beats);
        int               first;
        int               pick;
        int               choose;
        logic             rs;
        logic [BYTE_W-1:0] b;
        first = beats_in;
        program_waits($urandom_range(1, 65535), $urandom_range(1, 65535),
                      $urandom_range(1, 65535), $urandom_range(0, 4), $urandom_range(0, 6));
        while (beats_in - first < beats)
        begin
            pick = $urandom_range(99);
            rs = 1'($urandom_range(1));
            b = BYTE_W'($urandom_range(255));
            if (pick < 70)
            begin
                choose = $urandom_range(9);
                if (choose < 2)
                begin
                    rs = 1'b0;
                    b = CMD_CLEAR;
                end
                else if (choose < 4)
                begin
                    rs = 1'b0;
                    b = CMD_SET_CURSOR | BYTE_W'($urandom_range(127));
                end
                send_beat(KIND_WRITE, rs, b);
                send_ticks(xfer_ticks(!rs && b == CMD_CLEAR) + $urandom_range(2));
            end
            else if (pick < 85)
            begin
                send_beat(KIND_WRITE, rs, b);
                send_ticks($urandom_range(3));
            end
            else
                send_ticks($urandom_range(1, 4));
        end
        drain_pipe();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = KIND_TICK;
        reg_select = 1'b0;
        data_byte = '0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_POWER_ON_WAIT;
        cfg_data = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // restart the power-on wait twice, the second time part-way through
        write_reg(CFG_POWER_ON_WAIT, 16'hFFFF);
        end_writes();
        send_ticks(3);
        drain_pipe();
        write_reg(CFG_SPARE_LO, CFG_W'($urandom_range(65535)));
        program_waits(2, 1, 1, 0, 1);

        // init sequence, with requests turned away while it runs
        send_ticks(4);
        send_beat(KIND_WRITE, 1'b1, 8'hA5);
        send_ticks(2 + 4 * 1 + 1 + 1 + 4 * xfer_ticks(1'b0) - 4);
        send_beat(KIND_WRITE, 1'b0, 8'h00);

        send_beat(KIND_WRITE, 1'b0, CMD_CLEAR);
        send_beat(KIND_WRITE, 1'b1, 8'hFF);
        send_ticks(xfer_ticks(1'b1));
        send_beat(KIND_WRITE, 1'b1, 8'hFF);
        send_beat(KIND_TICK, 1'b1, 8'hFF);
        send_ticks(xfer_ticks(1'b0) - 1);
        send_beat(KIND_WRITE, 1'b1, CMD_CLEAR);
        send_ticks(xfer_ticks(1'b0));
        send_beat(KIND_WRITE, 1'b0, CMD_SET_CURSOR | 8'h4F);
        send_ticks(xfer_ticks(1'b0) + 2);
        drain_pipe();

        // hold off the output while the sender keeps offering beats
        hold_req <= 1'b1;
        random_phase(RANDOM_BEATS);

        send_idle = 76;
        random_phase(RANDOM_BEATS);

        send_idle = 0;
        recv_stall <= 76;
        random_phase(RANDOM_BEATS);

        send_idle = 35;
        recv_stall <= 35;
        random_phase(RANDOM_BEATS);

        // load the longest settle and clear waits; requests inside them are dropped
        send_idle = 0;
        recv_stall <= 0;
        write_reg(CFG_SPARE_HI, 16'h0000);
        program_waits(65535, 65535, 65535, 65535, 65535);
        send_beat(KIND_WRITE, 1'b0, CMD_CLEAR);
        send_ticks(8);
        send_beat(KIND_WRITE, 1'b1, 8'h5A);
        send_ticks(3);
        drain_pipe();

        $display("%0d beats in, %0d beats out, %0d register writes in %0d cycles",
                 beats_in, beats_out, cfg_writes, cycle_count);
        $display("power-on restarts, init, clears, %0d busy rejections, %0d enable strobes",
                 rejects_seen, strobes_seen);
        if (mismatches == 0 && pending == 0)
            $display("char_lcd_four_bit_interface_core: match");
        else
            $display("char_lcd_four_bit_interface_core: mismatch");
        $finish;
    end

endmodule
